// ----- rtl/set_assoc_writeback_cache_macros.svh -----
// Assertion macros for the set-associative write-back cache checker.
// Included by the checker file only.
`ifndef SET_ASSOC_WRITEBACK_CACHE_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define SAWC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// a stalled request keeps valid high and the signal stable
`define SAWC_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig) \
  `SAWC_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> vld && $stable(sig))
`endif

// ----- rtl/sawc_pkg.sv -----
// Package for the set-associative write-back cache: geometry, codes, types.
// No dependencies.
package sawc_pkg;
  localparam int LOG2_LINES = 5;
  localparam int LOG2_WAYS  = 1;
  localparam int LINE_WORDS = 4;
  localparam int ADDR_BITS  = 16;
  localparam int NUM_LINES  = 1 << LOG2_LINES;
  localparam int NUM_WAYS   = 1 << LOG2_WAYS;
  localparam int SET_BITS   = LOG2_LINES - LOG2_WAYS;
  localparam int OFF_BITS   = $clog2(LINE_WORDS);
  localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int WORD_BITS  = LOG2_LINES + OFF_BITS;
  localparam int WAY_BITS   = (LOG2_WAYS > 0) ? LOG2_WAYS : 1;

  typedef enum logic [1:0] {
    CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_FILL = 2'd2, CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_READ = 3'd0, KIND_WDONE = 3'd1, KIND_WB = 3'd2, KIND_FREQ = 3'd3,
    KIND_RETRY = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_WB, ST_FREQ, ST_FRD, ST_ACC, ST_OUT
  } state_e;

  typedef struct packed {
    logic       take_in;
    logic       look;
    logic       wb_step;
    logic       fill_wr;
    logic       do_acc;
    logic       freq;
    logic       retry;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic       cmd_fill;
    logic       cmd_acc;
    logic       pend;
    logic       hit;
    logic       victim_dirty;
    logic       wb_last;
    logic       fill_last;
  } dp_sts_t;
endpackage

// ----- rtl/sawc_req_if.sv -----
// Request and result channel interfaces with valid/ready handshake.
// The request interface imports sawc_pkg; field widths are written as literals.
interface sawc_in_if;
  import sawc_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic signed [31:0] data_in;
  modport source (output valid, command, address, data_in, input ready);
  modport sink (input valid, command, address, data_in, output ready);
endinterface

interface sawc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [15:0] out_address;
  logic signed [31:0] out_data;
  logic        last;
  modport source (output valid, result_kind, out_address, out_data, last, input ready);
  modport sink (input valid, result_kind, out_address, out_data, last, output ready);
endinterface

// ----- rtl/sawc_ctrl.sv -----
// Controller state machine of the cache: sequences lookup, writeback,
// fill and result delivery. Depends on sawc_pkg.
module sawc_ctrl import sawc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_IDLE;
        if (sts_i.cmd_fill) begin
          if (sts_i.pend) begin
            cmd_o.fill_wr = 1'b1;
            if (sts_i.fill_last) state_d = ST_FRD;
          end
        end else if (sts_i.cmd_acc) begin
          if (sts_i.pend) begin
            cmd_o.retry = 1'b1;
            cmd_o.load_out = 1'b1;
            state_d = ST_OUT;
            ret_d = ST_IDLE;
          end else if (sts_i.hit) begin
            state_d = ST_ACC;
          end else begin
            cmd_o.look = 1'b1;
            state_d = sts_i.victim_dirty ? ST_WB : ST_FREQ;
          end
        end
      end
      ST_WB: begin
        cmd_o.wb_step = 1'b1;
        cmd_o.load_out = 1'b1;
        state_d = ST_OUT;
        ret_d = sts_i.wb_last ? ST_FREQ : ST_WB;
      end
      ST_FREQ: begin
        cmd_o.freq = 1'b1;
        cmd_o.load_out = 1'b1;
        state_d = ST_OUT;
        ret_d = ST_IDLE;
      end
      // filled line is now a hit; word read happens here
      ST_FRD: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.do_acc = 1'b1;
        cmd_o.load_out = 1'b1;
        state_d = ST_OUT;
        ret_d = ST_IDLE;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ret_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/sawc_datapath.sv -----
// Datapath of the cache: tag, dirty and stamp arrays, word memory, pending
// access and result register. Depends on sawc_pkg.
module sawc_datapath import sawc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [31:0] data_in_i,
  output logic [2:0]  result_kind_o,
  output logic [15:0] out_address_o,
  output logic [31:0] out_data_o,
  output logic        last_o
);
  logic [TAG_BITS-1:0] tag_q [NUM_LINES];
  logic [NUM_LINES-1:0] valid_q, dirty_q;
  logic [31:0] stamp_q [NUM_LINES];
  logic [31:0] mem_q [2**WORD_BITS];
  logic [30:0] usage_q;

  logic [1:0]  icmd_q;
  logic [ADDR_BITS-1:0] iaddr_q;
  logic [31:0] idata_q;
  logic        pend_q, pwrite_q;
  logic [ADDR_BITS-1:0] paddr_q;
  logic [31:0] pdata_q;
  logic [OFF_BITS:0] fpos_q;
  logic [LOG2_LINES-1:0] vline_q;
  logic [OFF_BITS-1:0] wbpos_q;
  logic [31:0] rd_q;

  logic [2:0]  kind_q;
  logic [15:0] oaddr_q;
  logic [31:0] odata_q;
  logic        last_q;

  logic [ADDR_BITS-1:0] caddr;
  logic [SET_BITS-1:0] cset;
  logic [TAG_BITS-1:0] ctag;
  logic [OFF_BITS-1:0] coff;
  logic        hit;
  logic [LOG2_LINES-1:0] hit_line, vic_line, acc_line;
  logic [WAY_BITS-1:0] best;
  logic [LOG2_LINES-1:0] tl;
  logic [WORD_BITS-1:0] raddr;
  logic        rd_en;

  assign caddr = pend_q ? paddr_q : iaddr_q;
  assign coff  = caddr[OFF_BITS-1:0];
  assign cset  = caddr[OFF_BITS +: SET_BITS];
  assign ctag  = caddr[ADDR_BITS-1 -: TAG_BITS];

  always_comb begin
    hit = 1'b0;
    hit_line = '0;
    best = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      tl = {cset, WAY_BITS'(i)} >> (WAY_BITS - LOG2_WAYS);
      if (!hit && valid_q[tl] && tag_q[tl] == ctag) begin
        hit = 1'b1;
        hit_line = tl;
      end
    end
    for (int i = 1; i < NUM_WAYS; i++) begin
      tl = {cset, WAY_BITS'(i)} >> (WAY_BITS - LOG2_WAYS);
      if ((stamp_q[tl] ^ 32'h8000_0000) <
          (stamp_q[({cset, best} >> (WAY_BITS - LOG2_WAYS))] ^ 32'h8000_0000))
        best = WAY_BITS'(i);
    end
    tl = '0;
    vic_line = LOG2_LINES'({cset, best} >> (WAY_BITS - LOG2_WAYS));
  end

  assign acc_line = hit ? hit_line : vline_q;

  assign sts_o.cmd_fill     = (icmd_q == CMD_FILL);
  assign sts_o.cmd_acc      = (icmd_q == CMD_READ) || (icmd_q == CMD_WRITE);
  assign sts_o.pend         = pend_q;
  assign sts_o.hit          = hit;
  assign sts_o.victim_dirty = valid_q[vic_line] && dirty_q[vic_line];
  assign sts_o.wb_last      = (wbpos_q == OFF_BITS'(LINE_WORDS - 1));
  assign sts_o.fill_last    = (fpos_q == (OFF_BITS+1)'(LINE_WORDS - 1));

  // memory read: one port, registered
  always_comb begin
    rd_en = 1'b0;
    raddr = {vic_line, coff};
    if (cmd_i.look || cmd_i.wb_step) begin
      rd_en = 1'b1;
      raddr = {cmd_i.look ? vic_line : vline_q, cmd_i.look ? OFF_BITS'(0) : wbpos_q + 1'b1};
    end else if (!cmd_i.fill_wr && (!pend_q || hit)) begin
      rd_en = 1'b1;
      raddr = {hit_line, coff};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[raddr];
    if (cmd_i.fill_wr) mem_q[{vic_line, fpos_q[OFF_BITS-1:0]}] <= idata_q;
    if (cmd_i.do_acc && (pend_q ? pwrite_q : (icmd_q == CMD_WRITE)))
      mem_q[{acc_line, coff}] <= pend_q ? pdata_q : idata_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      icmd_q  <= command_i;
      iaddr_q <= address_i[ADDR_BITS-1:0];
      idata_q <= data_in_i;
    end
    if (cmd_i.look) begin
      paddr_q  <= iaddr_q;
      pdata_q  <= idata_q;
      pwrite_q <= (icmd_q == CMD_WRITE);
      vline_q  <= vic_line;
    end
    if (cmd_i.fill_wr) vline_q <= vic_line;
    if (cmd_i.load_out) begin
      kind_q  <= KIND_RETRY;
      oaddr_q <= 16'(iaddr_q);
      odata_q <= '0;
      last_q  <= 1'b1;
      if (cmd_i.wb_step) begin
        kind_q  <= KIND_WB;
        oaddr_q <= 16'({tag_q[vline_q], vline_q[LOG2_LINES-1 -: SET_BITS], wbpos_q});
        odata_q <= rd_q;
        last_q  <= 1'b0;
      end else if (cmd_i.freq) begin
        kind_q  <= KIND_FREQ;
        oaddr_q <= 16'({paddr_q[ADDR_BITS-1:OFF_BITS], OFF_BITS'(0)});
      end else if (cmd_i.do_acc) begin
        oaddr_q <= 16'(pend_q ? paddr_q : iaddr_q);
        if (pend_q ? pwrite_q : (icmd_q == CMD_WRITE)) begin
          kind_q <= KIND_WDONE;
        end else begin
          kind_q  <= KIND_READ;
          odata_q <= rd_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      usage_q <= '0;
      pend_q  <= 1'b0;
      fpos_q  <= '0;
      wbpos_q <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        stamp_q[i] <= '1;
        tag_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.look) begin
        pend_q  <= 1'b1;
        fpos_q  <= '0;
        wbpos_q <= '0;
      end
      if (cmd_i.wb_step) begin
        wbpos_q <= wbpos_q + 1'b1;
        if (sts_o.wb_last) dirty_q[vline_q] <= 1'b0;
      end
      if (cmd_i.fill_wr) begin
        fpos_q <= fpos_q + 1'b1;
        if (sts_o.fill_last) begin
          tag_q[vic_line]   <= ctag;
          valid_q[vic_line] <= 1'b1;
          dirty_q[vic_line] <= 1'b0;
          fpos_q <= '0;
        end
      end
      if (cmd_i.do_acc) begin
        pend_q <= 1'b0;
        if (pend_q ? pwrite_q : (icmd_q == CMD_WRITE)) dirty_q[acc_line] <= 1'b1;
        stamp_q[acc_line] <= (usage_q == 31'h7FFF_FFFF) ? 32'd0 : {1'b0, usage_q};
        usage_q <= usage_q + 1'b1;
      end
    end
  end

  assign result_kind_o = kind_q;
  assign out_address_o = oaddr_q;
  assign out_data_o    = odata_q;
  assign last_o        = last_q;
endmodule

// ----- rtl/set_assoc_writeback_cache.sv -----
// Top level of the set-associative write-back LRU cache: controller plus
// datapath, joined by command and status structs. Depends on sawc_pkg and
// the channel interfaces.
//
// One request at a time; the input is ready only while the controller idles.
// A hit passes the accept, lookup, access and result states, a retry accept,
// lookup and result, a fill word that does not end the line accept and lookup,
// and the closing fill word adds a state to read the filled word before access
// and result. A miss with a clean victim passes accept, lookup, fill request and
// result; a dirty victim adds a writeback and a result state per written-back
// word, since each result waits in the single output register until taken.
module set_assoc_writeback_cache import sawc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sawc_in_if.sink    req_i,
  sawc_out_if.source res_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  sawc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_ready_i(res_o.ready),
    .out_valid_o(res_o.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sawc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .command_i    (req_i.command),
    .address_i    (req_i.address),
    .data_in_i    (req_i.data_in),
    .result_kind_o(res_o.result_kind),
    .out_address_o(res_o.out_address),
    .out_data_o   (res_o.out_data),
    .last_o       (res_o.last)
  );
endmodule

// ----- rtl/sawc_checker.sv -----
// Port-level checker for the cache, bound to the top level.
// Depends on sawc_pkg and the assertion macro header.
`include "set_assoc_writeback_cache_macros.svh"
module sawc_checker import sawc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [31:0] odata,
  input logic        last
);
  `SAWC_ASSERT(a_no_overlap, clk_i, rst_ni, out_valid |-> !in_ready)
  `SAWC_ASSERT(a_kind_range, clk_i, rst_ni, out_valid |-> kind <= KIND_RETRY)
  `SAWC_ASSERT(a_wb_not_last, clk_i, rst_ni, (out_valid && kind == KIND_WB) |-> !last)
  `SAWC_ASSERT(a_zero_data, clk_i, rst_ni, (out_valid && (kind == KIND_WDONE || kind == KIND_FREQ || kind == KIND_RETRY)) |-> odata == 0)
  `SAWC_ASSERT_HOLD(a_hold, clk_i, rst_ni, out_valid, out_ready, kind)
endmodule

bind set_assoc_writeback_cache sawc_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(req_i.valid), .in_ready(req_i.ready),
  .out_valid(res_o.valid), .out_ready(res_o.ready),
  .kind(res_o.result_kind), .odata(res_o.out_data), .last(res_o.last)
);

// ----- tb/tb_set_assoc_writeback_cache.sv -----
// Testbench for set_assoc_writeback_cache: a directed table, then random requests.
// Results are checked against an in-bench cache predictor.
// Depends on sawc_pkg, sawc_in_if/sawc_out_if and the cache RTL.
module tb_set_assoc_writeback_cache;
  import sawc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_e       kind;
    logic [15:0] addr;
    logic [31:0] data;
    logic        last;
  } res_t;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] addr;
    logic [31:0] data;
    bit          chk;
    res_t        res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  sawc_in_if  req();
  sawc_out_if res();

  set_assoc_writeback_cache i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  // cache shadow state
  logic [31:0]         words  [NUM_LINES*LINE_WORDS];
  logic [TAG_BITS-1:0] tags   [NUM_LINES];
  bit                  valid  [NUM_LINES];
  bit                  dirty  [NUM_LINES];
  logic [31:0]         stamps [NUM_LINES];
  logic [30:0]         use_cnt;
  bit                  pend_vld;
  bit                  pend_wr;
  logic [15:0]         pend_addr;
  logic [31:0]         pend_data;
  int                  fill_pos;

  res_t exp_q[$];
  int   n_err;
  int   n_push;
  bit   idle_on;

  function automatic int victim_of(int set);
    int best;
    best = set * NUM_WAYS;
    for (int i = 1; i < NUM_WAYS; i++) begin
      if ((stamps[set*NUM_WAYS+i] ^ 32'h8000_0000) < (stamps[best] ^ 32'h8000_0000))
        best = set * NUM_WAYS + i;
    end
    return best;
  endfunction

  function automatic void push_res(kind_e k, logic [15:0] a, logic [31:0] d, logic l);
    res_t r;
    r.kind = k; r.addr = a; r.data = d; r.last = l;
    exp_q.push_back(r);
    n_push++;
  endfunction

  function automatic void cache_access(bit wr, logic [15:0] a, logic [31:0] d, int ln);
    int w;
    w = ln * LINE_WORDS + a[OFF_BITS-1:0];
    if (wr) begin
      words[w] = d;
      dirty[ln] = 1;
      push_res(KIND_WDONE, a, '0, 1'b1);
    end else begin
      push_res(KIND_READ, a, words[w], 1'b1);
    end
    stamps[ln] = (use_cnt == 31'h7FFF_FFFF) ? 32'd0 : {1'b0, use_cnt};
    use_cnt = use_cnt + 1;
  endfunction

  function automatic void predict_cache(cmd_e cmd, logic [15:0] a, logic [31:0] d);
    int set, v, hit;
    logic [TAG_BITS-1:0] tag;
    logic [15:0] base;
    if (cmd == CMD_FILL) begin
      if (!pend_vld) return;
      set = pend_addr[OFF_BITS +: SET_BITS];
      v = victim_of(set);
      words[v*LINE_WORDS + fill_pos] = d;
      fill_pos++;
      if (fill_pos < LINE_WORDS) return;
      tags[v] = pend_addr[15 -: TAG_BITS];
      valid[v] = 1;
      dirty[v] = 0;
      fill_pos = 0;
      pend_vld = 0;
      cache_access(pend_wr, pend_addr, pend_data, v);
      return;
    end
    if (cmd == CMD_NONE) return;
    if (pend_vld) begin
      push_res(KIND_RETRY, a, '0, 1'b1);
      return;
    end
    set = a[OFF_BITS +: SET_BITS];
    tag = a[15 -: TAG_BITS];
    hit = -1;
    for (int i = 0; i < NUM_WAYS; i++)
      if (hit < 0 && valid[set*NUM_WAYS+i] && tags[set*NUM_WAYS+i] == tag)
        hit = set * NUM_WAYS + i;
    if (hit >= 0) begin
      cache_access(cmd == CMD_WRITE, a, d, hit);
      return;
    end
    v = victim_of(set);
    if (valid[v] && dirty[v]) begin
      base = {tags[v], set[SET_BITS-1:0], {OFF_BITS{1'b0}}};
      for (int i = 0; i < LINE_WORDS; i++)
        push_res(KIND_WB, base + 16'(i), words[v*LINE_WORDS+i], 1'b0);
      dirty[v] = 0;
    end
    push_res(KIND_FREQ, {a[15:OFF_BITS], {OFF_BITS{1'b0}}}, '0, 1'b1);
    pend_vld = 1;
    pend_wr = (cmd == CMD_WRITE);
    pend_addr = a;
    pend_data = d;
    fill_pos = 0;
  endfunction

  function automatic void compare_res(res_t e, res_t a);
    if (e.kind !== a.kind || e.addr !== a.addr || e.data !== a.data || e.last !== a.last) begin
      n_err++;
      if (n_err <= 10)
        $display("mismatch: exp kind %0d addr %h data %h last %0b, %s %0d addr %h data %h last %0b",
                 e.kind, e.addr, e.data, e.last, "got kind", a.kind, a.addr, a.data, a.last);
    end
  endfunction

  task automatic send_req(cmd_e cmd, logic [15:0] a, logic [31:0] d);
    while (idle_on && $urandom_range(99) < 31) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.address <= a;
    req.data_in <= d;
    do @(posedge clk_i); while (!req.ready);
    predict_cache(cmd, a, d);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    wait (exp_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("tb_set_assoc_writeback_cache: FAIL");
    $finish;
  end

  // result sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    res_t act;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= !(idle_on && $urandom_range(99) < 31);
      if (res.valid && res.ready) begin
        act.kind = kind_e'(res.result_kind);
        act.addr = res.out_address;
        act.data = res.out_data;
        act.last = res.last;
        if (exp_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("unexpected result: kind %0d addr %h data %h", act.kind, act.addr, act.data);
        end else begin
          compare_res(exp_q.pop_front(), act);
        end
      end
    end
  end

  function automatic row_t mk(cmd_e c, logic [15:0] a, logic [31:0] d, bit chk = 0,
                              kind_e k = KIND_READ, logic [15:0] ea = '0,
                              logic [31:0] ed = '0);
    row_t r;
    r.cmd = c; r.addr = a; r.data = d; r.chk = chk;
    r.res.kind = k; r.res.addr = ea; r.res.data = ed; r.res.last = 1'b1;
    return r;
  endfunction

  initial begin
    row_t        dir[$];
    int          n0;
    cmd_e        c;
    logic [15:0] a;
    int          p;

    rst_ni      = 1'b0;
    req.valid   = 1'b0;
    req.command = CMD_NONE;
    req.address = '0;
    req.data_in = '0;
    idle_on     = 1'b1;
    n_err       = 0;
    n_push      = 0;
    for (int i = 0; i < NUM_LINES; i++) begin
      valid[i] = 0; dirty[i] = 0; tags[i] = '0; stamps[i] = '1;
    end
    use_cnt = '0; pend_vld = 0; pend_wr = 0; pend_addr = '0; pend_data = '0; fill_pos = 0;

    dir.push_back(mk(CMD_FILL, 16'h0000, 32'hDEAD_BEEF));
    dir.push_back(mk(CMD_READ, 16'h0000, 32'h0, 1, KIND_FREQ, 16'h0000));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h0000_0011));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h0000_0022));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h0000_0033));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h0000_0044, 1, KIND_READ, 16'h0000, 32'h11));
    dir.push_back(mk(CMD_WRITE, 16'hFFFF, 32'h7FFF_FFFF, 1, KIND_FREQ, 16'hFFFC));
    dir.push_back(mk(CMD_READ, 16'h1234, 32'h0, 1, KIND_RETRY, 16'h1234));
    dir.push_back(mk(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h8000_0000));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'hFFFF_FFFF));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h0000_0000));
    dir.push_back(mk(CMD_FILL, 16'h0000, 32'h5555_5555, 1, KIND_WDONE, 16'hFFFF));
    dir.push_back(mk(CMD_READ, 16'hFFFF, 32'h0, 1, KIND_READ, 16'hFFFF, 32'h7FFF_FFFF));
    dir.push_back(mk(CMD_READ, 16'h003C, 32'h0, 1, KIND_FREQ, 16'h003C));
    for (int i = 0; i < LINE_WORDS; i++)
      dir.push_back(mk(CMD_FILL, 16'h0000, 32'hA5A5_0000 + i));
    dir.push_back(mk(CMD_WRITE, 16'h007E, 32'h8000_0001));
    for (int i = 0; i < LINE_WORDS; i++)
      dir.push_back(mk(CMD_FILL, 16'h0000, 32'h5A5A_0000 + i));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) begin
      n0 = n_push;
      send_req(dir[i].cmd, dir[i].addr, dir[i].data);
      if (dir[i].chk) begin
        if (n_push == n0) begin
          n_err++;
          if (n_err <= 10) $display("table row %0d produced no result", i);
        end else begin
          compare_res(dir[i].res, exp_q[exp_q.size() - (n_push - n0)]);
        end
      end
    end
    drain();

    for (int n = 0; n < 300; n++) begin
      idle_on = !(n >= 100 && n < 180);
      if (n == 220) drain();
      p = $urandom_range(99);
      if (pend_vld) begin
        c = (p < 80) ? CMD_FILL : (p < 92) ? cmd_e'($urandom_range(1)) : CMD_NONE;
      end else begin
        c = (p < 5) ? CMD_FILL : (p < 9) ? CMD_NONE : cmd_e'($urandom_range(1));
      end
      if ($urandom_range(99) < 25)
        a = 16'($urandom);
      else
        a = {2'($urandom_range(3)), 8'h00, 6'($urandom)};
      send_req(c, a, $urandom);
    end

    req.valid <= 1'b0;
    wait (exp_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_err == 0)
      $display("tb_set_assoc_writeback_cache: PASS");
    else
      $display("tb_set_assoc_writeback_cache: FAIL");
    $finish;
  end
endmodule

// ----- set_assoc_writeback_cache.f -----
+incdir+rtl
rtl/sawc_pkg.sv
rtl/sawc_req_if.sv
rtl/sawc_ctrl.sv
rtl/sawc_datapath.sv
rtl/set_assoc_writeback_cache.sv
rtl/sawc_checker.sv
tb/tb_set_assoc_writeback_cache.sv
